// ===== design/wrrf_pkg.sv =====
package wrrf_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_MAX_HALF    = 7;
    localparam int DEF_SAMPLE_BITS = 24;

    localparam int COORD_BITS  = 12;
    localparam int COORD_LIMIT = 4096;
    localparam int DIM_BITS    = 13;
    localparam int HALF_BITS   = 3;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_SCAN   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_OUT    = 6'b010000,
        S_SPARE  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_HALF   = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef struct packed {
        logic clear;
        logic take;
    } t_acc_ctl;

endpackage

// ===== design/wrrf_extreme.sv =====
module wrrf_extreme #(
    parameter int SAMPLE_BITS = wrrf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  wrrf_pkg::t_acc_ctl            i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_any,
    output logic        [SAMPLE_BITS-1:0] o_range
);

    logic                          r_any;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_any <= 1'b0;
        end else if (i_ctl.take) begin
            r_any <= 1'b1;
            if (!r_any || i_sample < r_min) begin
                r_min <= i_sample;
            end
            if (!r_any || i_sample > r_max) begin
                r_max <= i_sample;
            end
        end
    end

    assign o_any   = r_any;
    assign o_range = SAMPLE_BITS'(r_max - r_min);

endmodule

// ===== design/window_range_relief_filter_top.sv =====
// Channel   Direction  Handshake                   Payload
// input     in         i_valid / o_ready           i_cmd, i_elevation, i_elev_valid
// result    out        o_valid / i_ready           o_relief, o_relief_valid, o_out_column,
//                                                  o_out_row, o_last
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item without a result goes from check back to idle. One with a result goes
// on to scan, drain and output, waiting there on i_ready: the window is read from
// the row store one sample per cycle through its single read port.
// Reset is synchronous, active low; the row store has no reset and needs no clearing.
// One item is in flight at a time; a stalled result holds the input side off.
module window_range_relief_filter_top #(
    parameter int MAX_WIDTH   = wrrf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HALF    = wrrf_pkg::DEF_MAX_HALF,
    parameter int SAMPLE_BITS = wrrf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_elevation,
    input  logic                   i_elev_valid,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SAMPLE_BITS-1:0] o_relief,
    output logic                   o_relief_valid,
    output logic [11:0]            o_out_column,
    output logic [11:0]            o_out_row,
    output logic                   o_last,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [12:0]            i_cfg_data
);

    localparam int CB    = wrrf_pkg::COORD_BITS;
    localparam int DB    = wrrf_pkg::DIM_BITS;
    localparam int RING  = 2 * MAX_HALF + 2;
    localparam int SLB   = $clog2(RING);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int XB    = $clog2(MAX_WIDTH);
    localparam int KB    = $clog2(MAX_HALF + 1);
    localparam int OB    = $clog2(2 * MAX_HALF + 1);
    localparam int SW    = DB + 1;
    localparam int WLIM  = (MAX_WIDTH < wrrf_pkg::COORD_LIMIT) ? MAX_WIDTH
                                                                : wrrf_pkg::COORD_LIMIT;

    wrrf_pkg::t_state r_state, n_state;

    logic [DB-1:0]  r_img_w, r_img_h;
    logic [2:0]     r_half;
    logic [CB-1:0]  r_scan_col, r_scan_row, r_emit_col, r_emit_row;
    logic [SLB-1:0] r_scan_slot, r_emit_slot, r_win_slot;
    logic           r_full;
    logic [OB-1:0]  r_dr, r_dc;
    logic           r_pend, r_pend_incl, r_centre_pend, r_centre_ok;

    logic [SAMPLE_BITS:0] r_mem [DEPTH];
    logic [SAMPLE_BITS:0] r_rd;

    logic [DB-1:0] w_eff, h_eff;
    logic [KB-1:0] k_eff;

    always_comb begin
        if (r_img_w == '0) begin
            w_eff = DB'(1);
        end else if (r_img_w > DB'(WLIM)) begin
            w_eff = DB'(WLIM);
        end else begin
            w_eff = r_img_w;
        end
        if (r_img_h == '0) begin
            h_eff = DB'(1);
        end else if (r_img_h > DB'(wrrf_pkg::COORD_LIMIT)) begin
            h_eff = DB'(wrrf_pkg::COORD_LIMIT);
        end else begin
            h_eff = r_img_h;
        end
        if (r_half == '0) begin
            k_eff = KB'(1);
        end else if (5'(r_half) > 5'(MAX_HALF)) begin
            k_eff = KB'(MAX_HALF);
        end else begin
            k_eff = KB'(r_half);
        end
    end

    logic in_acc, out_acc, cfg_acc, is_pixel;
    assign o_ready     = (r_state == wrrf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign is_pixel    = (i_cmd == wrrf_pkg::CMD_PIXEL) && !r_full;

    // Emission test: every pixel of the window has arrived.
    logic [DB-1:0] tr, tc, h_m1, w_m1;
    logic          ready_to_emit;
    always_comb begin
        h_m1 = h_eff - DB'(1);
        w_m1 = w_eff - DB'(1);
        tr = {1'b0, r_emit_row} + DB'(k_eff);
        if (tr > h_m1) tr = h_m1;
        tc = {1'b0, r_emit_col} + DB'(k_eff);
        if (tc > w_m1) tc = w_m1;
        ready_to_emit = r_full || ({1'b0, r_scan_row} > tr)
                        || (({1'b0, r_scan_row} == tr) && ({1'b0, r_scan_col} > tc));
    end

    // Window position of the current read.
    logic signed [SW-1:0] win_r, win_c;
    logic                 win_incl, win_done;
    logic [OB-1:0]        two_k;
    always_comb begin
        two_k = OB'({k_eff, 1'b0});
        win_r = $signed(SW'(r_emit_row)) - $signed(SW'(k_eff)) + $signed(SW'(r_dr));
        win_c = $signed(SW'(r_emit_col)) - $signed(SW'(k_eff)) + $signed(SW'(r_dc));
        win_incl = (win_r > 0) && (win_r < $signed(SW'(h_m1)))
                   && (win_c > 0) && (win_c < $signed(SW'(w_m1)));
        win_done = (r_dr == two_k) && (r_dc == two_k);
    end

    logic [AW-1:0]  rd_addr, wr_addr;
    logic [SLB-1:0] start_slot;
    always_comb begin
        wr_addr = AW'(r_scan_slot) * AW'(MAX_WIDTH) + AW'(XB'(r_scan_col));
        if (r_state == wrrf_pkg::S_SCAN) begin
            rd_addr = AW'(r_win_slot) * AW'(MAX_WIDTH)
                      + (win_incl ? AW'(XB'(win_c[CB-1:0])) : AW'(0));
        end else begin
            rd_addr = AW'(r_emit_slot) * AW'(MAX_WIDTH) + AW'(XB'(r_emit_col));
        end
        if (SLB'(k_eff) <= r_emit_slot) begin
            start_slot = r_emit_slot - SLB'(k_eff);
        end else begin
            start_slot = SLB'(r_emit_slot + SLB'(RING) - SLB'(k_eff));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && is_pixel) begin
            r_mem[wr_addr] <= {i_elev_valid, i_elevation};
        end
        r_rd <= r_mem[rd_addr];
    end

    wrrf_pkg::t_acc_ctl acc_ctl;
    logic                   acc_any;
    logic [SAMPLE_BITS-1:0] acc_range;
    assign acc_ctl.clear = (r_state == wrrf_pkg::S_CHECK);
    assign acc_ctl.take  = r_pend && r_pend_incl && r_rd[SAMPLE_BITS];

    wrrf_extreme #(.SAMPLE_BITS(SAMPLE_BITS)) u_extreme (
        .i_clk    (i_clk),
        .i_ctl    (acc_ctl),
        .i_sample (r_rd[SAMPLE_BITS-1:0]),
        .o_any    (acc_any),
        .o_range  (acc_range)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrrf_pkg::S_IDLE:  if (in_acc) n_state = wrrf_pkg::S_CHECK;
            wrrf_pkg::S_CHECK: n_state = ready_to_emit ? wrrf_pkg::S_SCAN : wrrf_pkg::S_IDLE;
            wrrf_pkg::S_SCAN:  if (win_done) n_state = wrrf_pkg::S_DRAIN;
            wrrf_pkg::S_DRAIN: n_state = wrrf_pkg::S_OUT;
            wrrf_pkg::S_OUT:   if (i_ready) n_state = wrrf_pkg::S_IDLE;
            default:           n_state = wrrf_pkg::S_IDLE;
        endcase
    end

    logic is_last;
    assign is_last = ({1'b0, r_emit_row} == h_m1) && ({1'b0, r_emit_col} == w_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= wrrf_pkg::S_IDLE;
            r_img_w       <= DB'(4096);
            r_img_h       <= DB'(4096);
            r_half        <= 3'd1;
            r_scan_col    <= '0;
            r_scan_row    <= '0;
            r_emit_col    <= '0;
            r_emit_row    <= '0;
            r_scan_slot   <= '0;
            r_emit_slot   <= '0;
            r_win_slot    <= '0;
            r_full        <= 1'b0;
            r_dr          <= '0;
            r_dc          <= '0;
            r_pend        <= 1'b0;
            r_pend_incl   <= 1'b0;
            r_centre_pend <= 1'b0;
            r_centre_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= (r_state == wrrf_pkg::S_SCAN);
            r_pend_incl <= win_incl;

            if (in_acc && is_pixel) begin
                if ({1'b0, r_scan_col} + DB'(1) >= w_eff) begin
                    if ({1'b0, r_scan_row} + DB'(1) >= h_eff) begin
                        r_full <= 1'b1;
                    end else begin
                        r_scan_col  <= '0;
                        r_scan_row  <= r_scan_row + CB'(1);
                        r_scan_slot <= (r_scan_slot == SLB'(RING - 1)) ? '0
                                                                       : r_scan_slot + SLB'(1);
                    end
                end else begin
                    r_scan_col <= r_scan_col + CB'(1);
                end
            end

            if (r_state == wrrf_pkg::S_CHECK) begin
                r_dr          <= '0;
                r_dc          <= '0;
                r_win_slot    <= start_slot;
                r_centre_pend <= 1'b1;
            end

            if (r_state == wrrf_pkg::S_SCAN) begin
                // The centre sample was read in the check cycle.
                if (r_centre_pend) begin
                    r_centre_ok   <= r_rd[SAMPLE_BITS];
                    r_centre_pend <= 1'b0;
                end
                if (r_dc == two_k) begin
                    r_dc       <= '0;
                    r_dr       <= r_dr + OB'(1);
                    r_win_slot <= (r_win_slot == SLB'(RING - 1)) ? '0 : r_win_slot + SLB'(1);
                end else begin
                    r_dc <= r_dc + OB'(1);
                end
            end

            if (out_acc) begin
                if (is_last) begin
                    r_scan_col  <= '0;
                    r_scan_row  <= '0;
                    r_scan_slot <= '0;
                    r_emit_col  <= '0;
                    r_emit_row  <= '0;
                    r_emit_slot <= '0;
                    r_full      <= 1'b0;
                end else if ({1'b0, r_emit_col} + DB'(1) >= w_eff) begin
                    r_emit_col  <= '0;
                    r_emit_row  <= r_emit_row + CB'(1);
                    r_emit_slot <= (r_emit_slot == SLB'(RING - 1)) ? '0
                                                                   : r_emit_slot + SLB'(1);
                end else begin
                    r_emit_col <= r_emit_col + CB'(1);
                end
            end

            if (cfg_acc && (i_cfg_index != wrrf_pkg::CFG_NONE)) begin
                unique case (i_cfg_index)
                    wrrf_pkg::CFG_WIDTH:  r_img_w <= i_cfg_data;
                    wrrf_pkg::CFG_HEIGHT: r_img_h <= i_cfg_data;
                    wrrf_pkg::CFG_HALF:   r_half  <= i_cfg_data[2:0];
                    default:              r_half  <= r_half;
                endcase
                r_scan_col  <= '0;
                r_scan_row  <= '0;
                r_scan_slot <= '0;
                r_emit_col  <= '0;
                r_emit_row  <= '0;
                r_emit_slot <= '0;
                r_full      <= 1'b0;
            end
        end
    end

    assign o_valid        = (r_state == wrrf_pkg::S_OUT);
    assign o_relief_valid = r_centre_ok && acc_any;
    assign o_relief       = o_relief_valid ? acc_range : '0;
    assign o_out_column   = r_emit_col;
    assign o_out_row      = r_emit_row;
    assign o_last         = is_last;

`ifndef SYNTHESIS
    a_scan_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> ({1'b0, r_scan_col} < w_eff))
        else $error("scan column beyond frame width");
    a_emit_behind_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_row <= r_scan_row)
        else $error("emit row ahead of scan row");
    a_slots_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scan_slot < SLB'(RING - 1) || r_scan_slot == SLB'(RING - 1))
        && (r_emit_slot < SLB'(RING - 1) || r_emit_slot == SLB'(RING - 1)))
        else $error("ring slot out of range");
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == wrrf_pkg::S_CHECK))
        else $error("accepted item not checked");
`endif

endmodule
